FILE: hdl/rcst_pkg.sv
// Shared types and constants for the wall column ray caster.
`timescale 1ns / 1ps

package rcst_pkg;

   // Map and field geometry
   localparam int MAP_SIZE   = 64;
   localparam int MAP_DEPTH  = MAP_SIZE * MAP_SIZE;
   localparam int MAP_AW     = $clog2(MAP_DEPTH);
   localparam int CELL_W     = $clog2(MAP_SIZE);
   localparam int TILE_W     = 8;
   localparam int POS_W      = 22;
   localparam int FRAC_W     = 16;
   localparam int DIR_W      = 16;
   localparam int DIR_FRAC   = 14;
   localparam int COL_W      = 10;
   localparam int SCR_W      = 11;
   localparam int ROW_W      = 10;
   localparam int MAX_SCREEN = 1024;
   localparam int MIN_HEIGHT = 2;
   localparam int TEX_WIDTH  = 64;
   localparam int TEX_W      = $clog2(TEX_WIDTH);
   localparam int TEX_SHIFT  = FRAC_W - TEX_W;

   // Datapath widths
   localparam int RD_W     = 28;
   localparam int CAM_W    = 27;
   localparam int MPOS_W   = CELL_W + 2;
   localparam int STEP_W   = FRAC_W + 1;
   localparam int NUM_W    = 24;
   localparam int ACC_W    = 52;
   localparam int DVD_W    = 52;
   localparam int DVS_W    = 28;
   localparam int MUL_A_W  = 18;
   localparam int MUL_B_W  = 31;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int DIST_W   = 24;
   localparam int LH_W     = 27;
   localparam int HALF_W   = NUM_W / 2;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [CAM_W-1:0]  CAM_ONE  = CAM_W'(1 << DIR_FRAC);

   // Request and register codes
   localparam logic REQ_TILE   = 1'b0;
   localparam logic REQ_RAY    = 1'b1;
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ACK,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MULX,
      S_MULY,
      S_RAYY,
      S_SETUP,
      S_MXA,
      S_MXB,
      S_ACCY,
      S_WALK_ADDR,
      S_WALK_DATA,
      S_HIT,
      S_MULH,
      S_MULL,
      S_NPROD,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      DIV_CAM,
      DIV_DIST,
      DIV_WALL,
      DIV_LH
   } div_op_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
      logic [TILE_W-1:0] data;
   } map_wr_type;

endpackage

FILE: hdl/rcst_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rcst_div
   import rcst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W+1:0] trial;
   logic [DVS_W:0]   shifted;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      shifted = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DVS_W+1]) begin
            rem_in = trial[DVS_W:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[DVS_W-1:0];

endmodule

FILE: hdl/rcst_map.sv
// Tile map store with a clearing pass after reset.
`timescale 1ns / 1ps

module rcst_map
   import rcst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  map_wr_type        map_wr,
   input  logic              rd_en,
   input  logic [MAP_AW-1:0] rd_addr,
   output logic [TILE_W-1:0] rd_data,
   output logic              clr_busy
);

   logic [TILE_W-1:0] mem [MAP_DEPTH];
   logic [MAP_AW:0]   clr_cnt_ff, clr_cnt_in;
   logic [TILE_W-1:0] rd_data_ff;
   logic              we;
   logic [MAP_AW-1:0] waddr;
   logic [TILE_W-1:0] wdata;

   // Sweep zeros through the store until the counter runs out
   always_comb begin
      clr_busy   = !clr_cnt_ff[MAP_AW];
      clr_cnt_in = clr_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      we         = clr_busy | map_wr.en;
      waddr      = clr_busy ? clr_cnt_ff[MAP_AW-1:0] : map_wr.addr;
      wdata      = clr_busy ? '0 : map_wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/wall_column_raycaster_core.sv
// A tile write is answered from the acknowledge state once the answer register is free.
// A ray runs up to four divisions in the shared divider (camera, distance, hit offset,
// line height; fewer when it leaves the map or runs parallel to the hit axis) and one
// registered tile read per cell. One request is in flight at a time; a held answer stalls.
// Reset: synchronous; all 4096 map cells are then cleared, no request is taken meanwhile.
`timescale 1ns / 1ps

module wall_column_raycaster_core
   import rcst_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic [CELL_W-1:0]       req_cell_x,
   input  logic [CELL_W-1:0]       req_cell_y,
   input  logic [TILE_W-1:0]       req_cell_value,
   input  logic [COL_W-1:0]        req_column,
   input  logic [POS_W-1:0]        req_pos_x,
   input  logic [POS_W-1:0]        req_pos_y,
   input  logic signed [DIR_W-1:0] req_dir_x,
   input  logic signed [DIR_W-1:0] req_dir_y,
   input  logic signed [DIR_W-1:0] req_plane_x,
   input  logic signed [DIR_W-1:0] req_plane_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_answer_kind,
   output logic [DIST_W-1:0]       rsp_wall_distance,
   output logic                    rsp_hit_side,
   output logic [TILE_W-1:0]       rsp_wall_tile,
   output logic [TEX_W-1:0]        rsp_tex_column,
   output logic [ROW_W-1:0]        rsp_draw_start,
   output logic [ROW_W-1:0]        rsp_draw_end,
   output logic                    rsp_escaped,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [SCR_W-1:0]        csr_wdata
);

   state_type state_ff, state_in;
   div_op_type div_op_ff, div_op_in;

   // Configuration
   logic [SCR_W-1:0] width_ff, height_ff;
   logic [SCR_W-1:0] w_eff, h_eff;

   // Request fields
   logic [COL_W-1:0]        column_ff, column_in;
   logic [POS_W-1:0]        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [DIR_W-1:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic signed [DIR_W-1:0] plane_x_ff, plane_x_in, plane_y_ff, plane_y_in;

   // Ray and walk state
   logic signed [CAM_W-1:0]  cam_ff, cam_in;
   logic signed [RD_W-1:0]   rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [RD_W-1:0]          ax, ay;
   logic [STEP_W-1:0]        dx0_ff, dx0_in, dy0_ff, dy0_in;
   logic [ACC_W-1:0]         accx_ff, accx_in, accy_ff, accy_in;
   logic signed [MPOS_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic                     side_ff, side_in;
   logic                     escaped_ff, escaped_in;
   logic [TILE_W-1:0]        tile_ff, tile_in;

   // Hit geometry
   logic [NUM_W-1:0]         absnum_ff, absnum_in;
   logic [RD_W-1:0]          absden_ff, absden_in, absoth_ff, absoth_in;
   logic [FRAC_W-1:0]        base_ff, base_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         pacc_ff, pacc_in, nprod_ff, nprod_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [TEX_W-1:0]         tex_ff, tex_in;
   logic [LH_W-1:0]          lh_ff, lh_in;

   // Shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff, prod_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_side_ff, rsp_side_in;
   logic [TILE_W-1:0] rsp_tile_ff, rsp_tile_in;
   logic [TEX_W-1:0]  rsp_tex_ff, rsp_tex_in;
   logic [ROW_W-1:0]  rsp_ds_ff, rsp_ds_in, rsp_de_ff, rsp_de_in;
   logic              rsp_esc_ff, rsp_esc_in;

   // Submodule links
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   map_wr_type        map_wr;
   logic              rd_en;
   logic [MAP_AW-1:0] rd_addr;
   logic [TILE_W-1:0] rd_data;
   logic              clr_busy;

   // Helpers
   logic                     req_acc;
   logic                     slot_free;
   logic                     out_of_map;
   logic                     step_x;
   logic [CELL_W-1:0]        hit_cell;
   logic                     hit_neg_dir;
   logic [CELL_W:0]          bound;
   logic signed [NUM_W-1:0]  num;
   logic signed [RD_W-1:0]   den, oth;
   logic [DVD_W-1:0]         qf, qs;
   logic [FRAC_W-1:0]        wall_lo;
   logic [TEX_W-1:0]         tex_raw;
   logic                     mirror;
   logic [ROW_W-1:0]         h_half;
   logic [LH_W-1:0]          lh_half;
   logic [LH_W:0]            de_sum;

   // Column widened for the camera dividend
   function automatic logic [COL_W:0] req_column_hold(input logic [COL_W-1:0] col);
      req_column_hold = {col, 1'b0} >> 1;
   endfunction

   assign req_ready = (state_ff == S_IDLE) && !clr_busy;
   assign req_acc   = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Clamp the screen registers
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = SCR_W'(1);
      else if (width_ff > SCR_W'(MAX_SCREEN)) w_eff = SCR_W'(MAX_SCREEN);
      h_eff = height_ff;
      if (height_ff < SCR_W'(MIN_HEIGHT)) h_eff = SCR_W'(MIN_HEIGHT);
      else if (height_ff > SCR_W'(MAX_SCREEN)) h_eff = SCR_W'(MAX_SCREEN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCR_W'(640);
         height_ff <= SCR_W'(480);
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   // Common decode of walk and hit geometry
   always_comb begin
      ax          = rdx_ff[RD_W-1] ? RD_W'(-rdx_ff) : RD_W'(rdx_ff);
      ay          = rdy_ff[RD_W-1] ? RD_W'(-rdy_ff) : RD_W'(rdy_ff);
      out_of_map  = mx_ff[MPOS_W-1] || mx_ff[MPOS_W-2] || my_ff[MPOS_W-1] || my_ff[MPOS_W-2];
      step_x      = accx_ff < accy_ff;
      hit_cell    = side_ff ? my_ff[CELL_W-1:0] : mx_ff[CELL_W-1:0];
      hit_neg_dir = side_ff ? rdy_ff[RD_W-1] : rdx_ff[RD_W-1];
      bound       = {1'b0, hit_cell} + (CELL_W+1)'(hit_neg_dir);
      num         = $signed({1'b0, bound, {FRAC_W{1'b0}}})
                    - $signed({2'b0, (side_ff ? pos_y_ff : pos_x_ff)});
      den         = side_ff ? rdy_ff : rdx_ff;
      oth         = side_ff ? rdx_ff : rdy_ff;
      qf          = (neg_ff && div_rsp.remainder != '0) ? div_rsp.quotient + 1'b1
                                                        : div_rsp.quotient;
      qs          = neg_ff ? -qf : qf;
      wall_lo     = base_ff + qs[FRAC_W-1:0];
      tex_raw     = TEX_W'(wall_lo >> TEX_SHIFT);
      mirror      = (!side_ff && !rdx_ff[RD_W-1] && rdx_ff != '0) || (side_ff && rdy_ff[RD_W-1]);
      h_half      = ROW_W'(h_eff >> 1);
      lh_half     = lh_ff >> 1;
      de_sum      = {1'b0, lh_half} + (LH_W+1)'(h_half);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_acc) state_in = (req_type == REQ_RAY) ? S_DIV_GO : S_ACK;
         S_ACK:       if (slot_free) state_in = S_IDLE;
         S_DIV_GO:    state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (div_op_ff)
                  DIV_CAM: state_in = S_MULX;
                  DIV_LH:  state_in = S_FIN;
                  default: state_in = S_DIV_GO;
               endcase
            end
         end
         S_MULX:      state_in = S_MULY;
         S_MULY:      state_in = S_RAYY;
         S_RAYY:      state_in = S_SETUP;
         S_SETUP:     state_in = S_MXA;
         S_MXA:       state_in = S_MXB;
         S_MXB:       state_in = S_ACCY;
         S_ACCY:      state_in = S_WALK_ADDR;
         S_WALK_ADDR: state_in = out_of_map ? S_FIN : S_WALK_DATA;
         S_WALK_DATA: state_in = (rd_data != '0) ? S_HIT : S_WALK_ADDR;
         S_HIT:       state_in = (den == '0) ? S_DIV_GO : S_MULH;
         S_MULH:      state_in = S_MULL;
         S_MULL:      state_in = S_NPROD;
         S_NPROD:     state_in = S_DIV_GO;
         S_FIN:       if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      div_op_in    = div_op_ff;
      column_in    = column_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      plane_x_in   = plane_x_ff;
      plane_y_in   = plane_y_ff;
      cam_in       = cam_ff;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      dx0_in       = dx0_ff;
      dy0_in       = dy0_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      side_in      = side_ff;
      escaped_in   = escaped_ff;
      tile_in      = tile_ff;
      absnum_in    = absnum_ff;
      absden_in    = absden_ff;
      absoth_in    = absoth_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      pacc_in      = pacc_ff;
      nprod_in     = nprod_ff;
      dist_in      = dist_ff;
      tex_in       = tex_ff;
      lh_in        = lh_ff;
      mul_a        = '0;
      mul_b        = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_tile_in  = rsp_tile_ff;
      rsp_tex_in   = rsp_tex_ff;
      rsp_ds_in    = rsp_ds_ff;
      rsp_de_in    = rsp_de_ff;
      rsp_esc_in   = rsp_esc_ff;
      map_wr.en    = 1'b0;
      map_wr.addr  = {req_cell_x, req_cell_y};
      map_wr.data  = req_cell_value;
      rd_en        = 1'b0;
      rd_addr      = {mx_ff[CELL_W-1:0], my_ff[CELL_W-1:0]};
      div_req.start = (state_ff == S_DIV_GO);

      // Divider operands follow the pending division
      case (div_op_ff)
         DIV_CAM: begin
            div_req.dividend = DVD_W'({req_column_hold(column_ff), {(DIR_FRAC+1){1'b0}}});
            div_req.divisor  = DVS_W'(w_eff);
         end
         DIV_DIST: begin
            div_req.dividend = DVD_W'({absnum_ff, {DIR_FRAC{1'b0}}});
            div_req.divisor  = absden_ff;
         end
         DIV_WALL: begin
            div_req.dividend = nprod_ff;
            div_req.divisor  = absden_ff;
         end
         default: begin
            div_req.dividend = DVD_W'({h_eff, {FRAC_W{1'b0}}});
            div_req.divisor  = (dist_ff == '0) ? DVS_W'(1) : DVS_W'(dist_ff);
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_type == REQ_TILE) begin
                  map_wr.en = 1'b1;
               end else begin
                  column_in  = req_column;
                  pos_x_in   = req_pos_x;
                  pos_y_in   = req_pos_y;
                  dir_x_in   = req_dir_x;
                  dir_y_in   = req_dir_y;
                  plane_x_in = req_plane_x;
                  plane_y_in = req_plane_y;
                  div_op_in  = DIV_CAM;
               end
            end
         end
         S_ACK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = REQ_TILE;
               rsp_dist_in  = '0;
               rsp_side_in  = 1'b0;
               rsp_tile_in  = '0;
               rsp_tex_in   = '0;
               rsp_ds_in    = '0;
               rsp_de_in    = '0;
               rsp_esc_in   = 1'b0;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (div_op_ff)
                  DIV_CAM: cam_in = CAM_W'(div_rsp.quotient) - CAM_ONE;
                  DIV_DIST: begin
                     dist_in   = (div_rsp.quotient > DVD_W'(DIST_MAX)) ? DIST_MAX
                                 : div_rsp.quotient[DIST_W-1:0];
                     div_op_in = DIV_WALL;
                  end
                  DIV_WALL: begin
                     tex_in    = mirror ? TEX_W'(TEX_WIDTH - 1) - tex_raw : tex_raw;
                     div_op_in = DIV_LH;
                  end
                  default: lh_in = div_rsp.quotient[LH_W-1:0];
               endcase
            end
         end
         S_MULX: begin
            mul_a = MUL_A_W'(plane_x_ff);
            mul_b = MUL_B_W'(cam_ff);
         end
         S_MULY: begin
            rdx_in = RD_W'(prod_ff >>> DIR_FRAC) + RD_W'(dir_x_ff);
            mul_a  = MUL_A_W'(plane_y_ff);
            mul_b  = MUL_B_W'(cam_ff);
         end
         S_RAYY: begin
            rdy_in = RD_W'(prod_ff >>> DIR_FRAC) + RD_W'(dir_y_ff);
         end
         S_SETUP: begin
            mx_in      = MPOS_W'(pos_x_ff[POS_W-1:FRAC_W]);
            my_in      = MPOS_W'(pos_y_ff[POS_W-1:FRAC_W]);
            dx0_in     = rdx_ff[RD_W-1] ? STEP_W'(pos_x_ff[FRAC_W-1:0])
                         : STEP_W'(1 << FRAC_W) - STEP_W'(pos_x_ff[FRAC_W-1:0]);
            dy0_in     = rdy_ff[RD_W-1] ? STEP_W'(pos_y_ff[FRAC_W-1:0])
                         : STEP_W'(1 << FRAC_W) - STEP_W'(pos_y_ff[FRAC_W-1:0]);
            side_in    = 1'b0;
            escaped_in = 1'b0;
         end
         S_MXA: begin
            mul_a = $signed({1'b0, dx0_ff});
            mul_b = $signed({3'b0, ay});
         end
         S_MXB: begin
            accx_in = ACC_W'(prod_ff);
            mul_a   = $signed({1'b0, dy0_ff});
            mul_b   = $signed({3'b0, ax});
         end
         S_ACCY: begin
            accy_in = ACC_W'(prod_ff);
         end
         S_WALK_ADDR: begin
            // Stop at the first cell outside the map, otherwise fetch the tile
            if (out_of_map) begin
               escaped_in = 1'b1;
               dist_in    = DIST_MAX;
               lh_in      = '0;
               tile_in    = TILE_W'(1);
               tex_in     = '0;
            end else begin
               rd_en = 1'b1;
            end
         end
         S_WALK_DATA: begin
            if (rd_data != '0) begin
               tile_in = rd_data;
            end else if (step_x) begin
               accx_in = accx_ff + (ACC_W'(ay) << FRAC_W);
               mx_in   = rdx_ff[RD_W-1] ? mx_ff - 1'b1 : mx_ff + 1'b1;
               side_in = 1'b0;
            end else begin
               accy_in = accy_ff + (ACC_W'(ax) << FRAC_W);
               my_in   = rdy_ff[RD_W-1] ? my_ff - 1'b1 : my_ff + 1'b1;
               side_in = 1'b1;
            end
         end
         S_HIT: begin
            absnum_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            absden_in = den[RD_W-1] ? RD_W'(-den) : RD_W'(den);
            absoth_in = oth[RD_W-1] ? RD_W'(-oth) : RD_W'(oth);
            base_in   = side_ff ? pos_x_ff[FRAC_W-1:0] : pos_y_ff[FRAC_W-1:0];
            neg_in    = num[NUM_W-1] ^ oth[RD_W-1] ^ den[RD_W-1];
            if (den == '0) begin
               // No crossing rate on this axis: saturate and use the base offset
               dist_in   = DIST_MAX;
               tex_in    = TEX_W'((side_ff ? pos_x_ff[FRAC_W-1:0]
                                           : pos_y_ff[FRAC_W-1:0]) >> TEX_SHIFT);
               div_op_in = DIV_LH;
            end else begin
               div_op_in = DIV_DIST;
            end
         end
         S_MULH: begin
            mul_a = $signed({{(MUL_A_W-HALF_W){1'b0}}, absnum_ff[NUM_W-1:HALF_W]});
            mul_b = $signed({3'b0, absoth_ff});
         end
         S_MULL: begin
            pacc_in = ACC_W'(prod_ff) << HALF_W;
            mul_a   = $signed({{(MUL_A_W-HALF_W){1'b0}}, absnum_ff[HALF_W-1:0]});
            mul_b   = $signed({3'b0, absoth_ff});
         end
         S_NPROD: begin
            nprod_in = pacc_ff + ACC_W'(prod_ff);
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = REQ_RAY;
               rsp_dist_in  = dist_ff;
               rsp_side_in  = side_ff;
               rsp_tile_in  = tile_ff - 1'b1;
               rsp_tex_in   = tex_ff;
               rsp_ds_in    = (lh_half >= LH_W'(h_half)) ? '0 : h_half - ROW_W'(lh_half);
               rsp_de_in    = (de_sum > (LH_W+1)'(h_eff - 1'b1)) ? ROW_W'(h_eff - 1'b1)
                              : ROW_W'(de_sum);
               rsp_esc_in   = escaped_ff;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_op_ff    <= DIV_CAM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_op_ff    <= div_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      column_ff  <= column_in;
      pos_x_ff   <= pos_x_in;
      pos_y_ff   <= pos_y_in;
      dir_x_ff   <= dir_x_in;
      dir_y_ff   <= dir_y_in;
      plane_x_ff <= plane_x_in;
      plane_y_ff <= plane_y_in;
      cam_ff     <= cam_in;
      rdx_ff     <= rdx_in;
      rdy_ff     <= rdy_in;
      dx0_ff     <= dx0_in;
      dy0_ff     <= dy0_in;
      accx_ff    <= accx_in;
      accy_ff    <= accy_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      side_ff    <= side_in;
      escaped_ff <= escaped_in;
      tile_ff    <= tile_in;
      absnum_ff  <= absnum_in;
      absden_ff  <= absden_in;
      absoth_ff  <= absoth_in;
      base_ff    <= base_in;
      neg_ff     <= neg_in;
      pacc_ff    <= pacc_in;
      nprod_ff   <= nprod_in;
      dist_ff    <= dist_in;
      tex_ff     <= tex_in;
      lh_ff      <= lh_in;
      prod_ff    <= prod_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_side_ff <= rsp_side_in;
      rsp_tile_ff <= rsp_tile_in;
      rsp_tex_ff  <= rsp_tex_in;
      rsp_ds_ff   <= rsp_ds_in;
      rsp_de_ff   <= rsp_de_in;
      rsp_esc_ff  <= rsp_esc_in;
   end

   rcst_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rcst_map u_map (
      .clock    (clock),
      .reset    (reset),
      .map_wr   (map_wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clr_busy (clr_busy)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_answer_kind   = rsp_kind_ff;
   assign rsp_wall_distance = rsp_dist_ff;
   assign rsp_hit_side      = rsp_side_ff;
   assign rsp_wall_tile     = rsp_tile_ff;
   assign rsp_tex_column    = rsp_tex_ff;
   assign rsp_draw_start    = rsp_ds_ff;
   assign rsp_draw_end      = rsp_de_ff;
   assign rsp_escaped       = rsp_esc_ff;

   // No request is taken while the map is being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !clr_busy)
      else $error("request ready during map clear");

   // A tile write answer carries only zeros
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_answer_kind |-> rsp_wall_distance == '0 && !rsp_escaped)
      else $error("tile write answer not zero");

   // An escaped ray reports saturated distance and no tile
   a_escape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escaped |-> rsp_wall_distance == DIST_MAX && rsp_wall_tile == '0)
      else $error("escaped ray result malformed");

   // The stripe never runs upward
   a_stripe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_answer_kind |-> rsp_draw_start <= rsp_draw_end)
      else $error("draw start past draw end");

   // The divider is started only when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

endmodule

FILE: sim/tb_wall_column_raycaster_core.sv
// Self-checking testbench for the wall column ray caster core.
`timescale 1ns / 1ps

module tb_wall_column_raycaster_core;
   import rcst_pkg::*;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam longint ONE_CELL    = 65536;
   localparam longint DIR_ONE     = 16384;
   localparam int     PHASE_ITEMS = 260;

   typedef struct packed {
      logic                    kind;
      logic [CELL_W-1:0]       cell_x;
      logic [CELL_W-1:0]       cell_y;
      logic [TILE_W-1:0]       cell_value;
      logic [COL_W-1:0]        column;
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] plane_x;
      logic signed [DIR_W-1:0] plane_y;
   } request_type;

   typedef struct packed {
      logic              kind;
      logic [DIST_W-1:0] distance;
      logic              side;
      logic [TILE_W-1:0] tile;
      logic [TEX_W-1:0]  tex;
      logic [ROW_W-1:0]  row_start;
      logic [ROW_W-1:0]  row_end;
      logic              escaped;
   } answer_type;

   typedef struct packed {
      request_type req;
      logic        fixed;
      answer_type  ans;
   } row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = REQ_TILE;
   logic [CELL_W-1:0]       req_cell_x = '0;
   logic [CELL_W-1:0]       req_cell_y = '0;
   logic [TILE_W-1:0]       req_cell_value = '0;
   logic [COL_W-1:0]        req_column = '0;
   logic [POS_W-1:0]        req_pos_x = '0;
   logic [POS_W-1:0]        req_pos_y = '0;
   logic signed [DIR_W-1:0] req_dir_x = '0;
   logic signed [DIR_W-1:0] req_dir_y = '0;
   logic signed [DIR_W-1:0] req_plane_x = '0;
   logic signed [DIR_W-1:0] req_plane_y = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_answer_kind;
   logic [DIST_W-1:0]       rsp_wall_distance;
   logic                    rsp_hit_side;
   logic [TILE_W-1:0]       rsp_wall_tile;
   logic [TEX_W-1:0]        rsp_tex_column;
   logic [ROW_W-1:0]        rsp_draw_start;
   logic [ROW_W-1:0]        rsp_draw_end;
   logic                    rsp_escaped;
   logic                    csr_write = 1'b0;
   logic                    csr_index = CSR_WIDTH;
   logic [SCR_W-1:0]        csr_wdata = '0;

   // Shadow of the block's state
   logic [TILE_W-1:0] map_copy [MAP_DEPTH];
   logic [SCR_W-1:0]  width_copy = 11'd640;
   logic [SCR_W-1:0]  height_copy = 11'd480;

   answer_type pending_answers [$];
   row_type    directed_rows [$];
   longint  cycles = 0;
   int      fail_count = 0;
   int      ray_count = 0;
   int      tile_count = 0;
   int      escape_count = 0;
   int      stall_left = 0;
   bit      quiet = 1'b0;

   wall_column_raycaster_core u_dut (.*);

   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      if (b < 0) begin
         a = -a;
         b = -b;
      end
      if (a >= 0) return a / b;
      q = (-a) / b;
      if (q * b != -a) q++;
      return -q;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Compute the answer for one request and apply its effect on the map copy
   function automatic answer_type cast_column(request_type r);
      longint w, h, cam, rdx, rdy, px, py, mx, my, sx, sy, ax, ay, ddx, ddy;
      longint num, den, oth, base, span, wall, lh, ds, de, texx;
      int     side;
      int     tile;
      bit     esc;
      answer_type a;
      a = '0;
      side = 0;
      tile = 0;
      esc = 1'b0;
      if (r.kind == REQ_TILE) begin
         map_copy[int'(r.cell_x) * MAP_SIZE + int'(r.cell_y)] = r.cell_value;
         return a;
      end
      w = width_copy;
      if (w < 1) w = 1;
      if (w > MAX_SCREEN) w = MAX_SCREEN;
      h = height_copy;
      if (h < MIN_HEIGHT) h = MIN_HEIGHT;
      if (h > MAX_SCREEN) h = MAX_SCREEN;
      cam = (2 * longint'(r.column) * DIR_ONE) / w - DIR_ONE;
      rdx = longint'(r.dir_x) + floor_quot(longint'(r.plane_x) * cam, DIR_ONE);
      rdy = longint'(r.dir_y) + floor_quot(longint'(r.plane_y) * cam, DIR_ONE);
      px = r.pos_x;
      py = r.pos_y;
      mx = px / ONE_CELL;
      my = py / ONE_CELL;
      sx = (rdx < 0) ? -1 : 1;
      sy = (rdy < 0) ? -1 : 1;
      ddx = (rdx < 0) ? px - mx * ONE_CELL : (mx + 1) * ONE_CELL - px;
      ddy = (rdy < 0) ? py - my * ONE_CELL : (my + 1) * ONE_CELL - py;
      ax = magnitude(rdx);
      ay = magnitude(rdy);
      // Walk the grid until a wall or the map edge
      forever begin
         if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) begin
            esc = 1'b1;
            break;
         end
         tile = map_copy[mx * MAP_SIZE + my];
         if (tile != 0) break;
         if (ddx * ay < ddy * ax) begin
            ddx += ONE_CELL;
            mx += sx;
            side = 0;
         end else begin
            ddy += ONE_CELL;
            my += sy;
            side = 1;
         end
      end
      texx = 0;
      if (esc) begin
         span = DIST_MAX;
         lh = 0;
         tile = 1;
      end else begin
         if (side == 0) begin
            num = (mx + ((sx < 0) ? 1 : 0)) * ONE_CELL - px;
            den = rdx;
            oth = rdy;
            base = py;
         end else begin
            num = (my + ((sy < 0) ? 1 : 0)) * ONE_CELL - py;
            den = rdy;
            oth = rdx;
            base = px;
         end
         if (den == 0) begin
            span = DIST_MAX;
            wall = base;
         end else begin
            span = (magnitude(num) * DIR_ONE) / magnitude(den);
            if (span > DIST_MAX) span = DIST_MAX;
            wall = base + floor_quot(num * oth, den);
         end
         texx = ((wall & 64'hFFFF) * TEX_WIDTH) >> 16;
         if ((side == 0 && rdx > 0) || (side == 1 && rdy < 0))
            texx = TEX_WIDTH - texx - 1;
         lh = (h * ONE_CELL) / ((span > 0) ? span : 1);
      end
      ds = h / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = h / 2 + lh / 2;
      if (de > h - 1) de = h - 1;
      a.kind = REQ_RAY;
      a.distance = span[DIST_W-1:0];
      a.side = side[0];
      a.tile = TILE_W'(tile - 1);
      a.tex = texx[TEX_W-1:0];
      a.row_start = ds[ROW_W-1:0];
      a.row_end = de[ROW_W-1:0];
      a.escaped = esc;
      return a;
   endfunction

   function automatic request_type tile_request(int x, int y, int v);
      request_type r;
      r = '0;
      r.kind = REQ_TILE;
      r.cell_x = CELL_W'(x);
      r.cell_y = CELL_W'(y);
      r.cell_value = TILE_W'(v);
      return r;
   endfunction

   function automatic request_type ray_request(int col, logic [POS_W-1:0] px,
                                               logic [POS_W-1:0] py, int dx, int dy,
                                               int plx, int ply);
      request_type r;
      r = '0;
      r.kind = REQ_RAY;
      r.column = COL_W'(col);
      r.pos_x = px;
      r.pos_y = py;
      r.dir_x = DIR_W'(dx);
      r.dir_y = DIR_W'(dy);
      r.plane_x = DIR_W'(plx);
      r.plane_y = DIR_W'(ply);
      return r;
   endfunction

   function automatic row_type predicted_row(request_type r);
      row_type row;
      row = '0;
      row.req = r;
      return row;
   endfunction

   // Tile write acknowledgements carry only the kind bit
   function automatic row_type acked_row(request_type r);
      row_type row;
      row = '0;
      row.req = r;
      row.fixed = 1'b1;
      return row;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic request_type random_request(int tile_pct);
      request_type r;
      r = '0;
      if ($urandom_range(0, 99) < tile_pct) begin
         r = tile_request($urandom_range(0, 63), $urandom_range(0, 63),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
      end else if ($urandom_range(0, 99) < 70) begin
         // Plausible camera: unit-scale direction and narrower plane
         r = ray_request($urandom_range(0, 1023), POS_W'($urandom),
                         POS_W'($urandom), int'($urandom_range(0, 32768)) - 16384,
                         int'($urandom_range(0, 32768)) - 16384,
                         int'($urandom_range(0, 22000)) - 11000,
                         int'($urandom_range(0, 22000)) - 11000);
      end else begin
         r = ray_request($urandom_range(0, 1023), POS_W'($urandom),
                         POS_W'($urandom), $urandom, $urandom, $urandom, $urandom);
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
      fail_count++;
   endtask

   // Present one request, hold it until accepted, then log its answer
   task automatic send_request(request_type r, logic fixed, answer_type fixed_ans);
      int gap;
      answer_type a;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_cell_x <= r.cell_x;
      req_cell_y <= r.cell_y;
      req_cell_value <= r.cell_value;
      req_column <= r.column;
      req_pos_x <= r.pos_x;
      req_pos_y <= r.pos_y;
      req_dir_x <= r.dir_x;
      req_dir_y <= r.dir_y;
      req_plane_x <= r.plane_x;
      req_plane_y <= r.plane_y;
      do @(posedge clock); while (!(req_valid && req_ready));
      a = cast_column(r);
      if (fixed) a = fixed_ans;
      if (r.kind == REQ_TILE) tile_count++;
      else ray_count++;
      if (a.escaped) escape_count++;
      pending_answers.push_back(a);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Write both screen registers while the block is idle
   task automatic set_screen(int w, int h);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= SCR_W'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= SCR_W'(h);
      @(posedge clock);
      csr_write <= 1'b0;
      width_copy = SCR_W'(w);
      height_copy = SCR_W'(h);
   endtask

   // Drive the response ready with random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 99) < 25)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 3);
      end
   end

   // Compare each answer with the oldest expectation
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected answer", 1, 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_answer_kind !== want.kind)
               report_mismatch("answer_kind", rsp_answer_kind, want.kind);
            if (rsp_wall_distance !== want.distance)
               report_mismatch("wall_distance", rsp_wall_distance, want.distance);
            if (rsp_hit_side !== want.side)
               report_mismatch("hit_side", rsp_hit_side, want.side);
            if (rsp_wall_tile !== want.tile)
               report_mismatch("wall_tile", rsp_wall_tile, want.tile);
            if (rsp_tex_column !== want.tex)
               report_mismatch("tex_column", rsp_tex_column, want.tex);
            if (rsp_draw_start !== want.row_start)
               report_mismatch("draw_start", rsp_draw_start, want.row_start);
            if (rsp_draw_end !== want.row_end)
               report_mismatch("draw_end", rsp_draw_end, want.row_end);
            if (rsp_escaped !== want.escaped)
               report_mismatch("escaped", rsp_escaped, want.escaped);
         end
      end
   end

   initial begin
      int w;
      int h;
      int phase;
      for (int i = 0; i < MAP_DEPTH; i++) map_copy[i] = '0;

      // Directed rows: extremes and corner cases
      directed_rows.push_back(predicted_row(ray_request(320, 22'h208000, 22'h208000,
                                                        16384, 0, 0, 10813)));
      directed_rows.push_back(acked_row(tile_request(0, 0, 255)));
      directed_rows.push_back(acked_row(tile_request(63, 63, 1)));
      directed_rows.push_back(acked_row(tile_request(40, 32, 7)));
      directed_rows.push_back(predicted_row(ray_request(320, 22'h208000, 22'h208000,
                                                        16384, 0, 0, 10813)));
      directed_rows.push_back(acked_row(tile_request(32, 40, 200)));
      directed_rows.push_back(predicted_row(ray_request(0, 22'h204000, 22'h20C000,
                                                        0, 16384, -10813, 0)));
      directed_rows.push_back(predicted_row(ray_request(320, 22'h208000, 22'h208000,
                                                        0, 16384, 0, 5000)));
      directed_rows.push_back(predicted_row(ray_request(77, 22'h208000, 22'h208000,
                                                        0, 0, 0, 0)));
      directed_rows.push_back(acked_row(tile_request(10, 10, 3)));
      directed_rows.push_back(predicted_row(ray_request(5, 22'h0A4000, 22'h0AC000,
                                                        0, 0, 0, 0)));
      directed_rows.push_back(predicted_row(ray_request(600, 22'h0A4000, 22'h0AC000,
                                                        -32768, 32767, 0, 0)));
      directed_rows.push_back(predicted_row(ray_request(1023, 22'h208000, 22'h208000,
                                                        -16384, 0, 0, 10813)));
      directed_rows.push_back(predicted_row(ray_request(0, 22'h000000, 22'h000000,
                                                        16384, 16384, 0, 0)));
      directed_rows.push_back(predicted_row(ray_request(1023, 22'h3FFFFF, 22'h3FFFFF,
                                                        -32768, -32768, 32767, 32767)));
      directed_rows.push_back(acked_row(tile_request(5, 5, 0)));
      directed_rows.push_back(acked_row(tile_request(40, 32, 0)));
      directed_rows.push_back(predicted_row(ray_request(320, 22'h208000, 22'h208000,
                                                        16384, 0, 0, 10813)));
      directed_rows.push_back(predicted_row(ray_request(1023, 22'h1F3333, 22'h2ACCCC,
                                                        32767, -32768, 32767, 32767)));
      directed_rows.push_back(predicted_row(ray_request(639, 22'h208001, 22'h20FFFF,
                                                        -11585, -11585, 7646, -7646)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].ans);

      // Close the map with a wall ring carrying random codes
      for (int k = 0; k < MAP_SIZE; k++) begin
         send_request(tile_request(k, 0, $urandom_range(1, 255)), 1'b0, '0);
         send_request(tile_request(k, 63, $urandom_range(1, 255)), 1'b0, '0);
         if (k > 0 && k < MAP_SIZE - 1) begin
            send_request(tile_request(0, k, $urandom_range(1, 255)), 1'b0, '0);
            send_request(tile_request(63, k, $urandom_range(1, 255)), 1'b0, '0);
         end
      end

      // Random phases, each under its own screen setting
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin w = 1; h = 2; end
            1: begin w = 1024; h = 1024; end
            2: begin w = 0; h = 2047; end
            3: begin w = 2047; h = 0; end
            default: begin
               w = $urandom_range(1, 1024);
               h = $urandom_range(2, 1024);
            end
         endcase
         set_screen(w, h);
         quiet = (phase == 4);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // In phase 3, hold off once mid-phase until all answers are back
            if (phase == 3 && k == PHASE_ITEMS / 2) wait_drained();
            send_request(random_request(30), 1'b0, '0);
         end
         quiet = 1'b0;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d tile writes and %0d rays (%0d left the map)",
               tile_count, ray_count, escape_count);
      $display("Screen settings included both register extremes and out-of-range values");
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
